/* src/aesrt_pkg.sv */
// ----------------------------------------------------------------------------
// AES round transforms package
// S-box table, GF(2^8) helpers and action codes shared by the lanes and top.
// ----------------------------------------------------------------------------
package aesrt_pkg;

  localparam logic [2:0] ACT_SUB   = 3'd0;
  localparam logic [2:0] ACT_SHIFT = 3'd1;
  localparam logic [2:0] ACT_MIX   = 3'd2;
  localparam logic [2:0] ACT_ROUND = 3'd3;
  localparam logic [2:0] ACT_FINAL = 3'd4;

  localparam int NumCols = 4;

  typedef logic [31:0] col_t;

  typedef struct packed {
    logic do_sub;
    logic do_shift;
    logic do_mix;
  } ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

/* src/aesrt_sub_lane.sv */
// ----------------------------------------------------------------------------
// AES S-box lane
// Substitutes the four bytes of one column when enabled.
// ----------------------------------------------------------------------------
module aesrt_sub_lane (
  input  aesrt_pkg::col_t col_in,
  input  logic            en,
  output aesrt_pkg::col_t col_out
);
  import aesrt_pkg::*;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      col_out[8*r +: 8] = en ? sbox(col_in[8*r +: 8]) : col_in[8*r +: 8];
    end
  end

endmodule

/* src/aesrt_mix_lane.sv */
// ----------------------------------------------------------------------------
// AES MixColumns lane
// Multiplies one column by the circulant matrix 02 03 01 01 when enabled.
// ----------------------------------------------------------------------------
module aesrt_mix_lane (
  input  aesrt_pkg::col_t col_in,
  input  logic            en,
  output aesrt_pkg::col_t col_out
);
  import aesrt_pkg::*;

  logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3;

  always_comb begin
    a0 = col_in[7:0];
    a1 = col_in[15:8];
    a2 = col_in[23:16];
    a3 = col_in[31:24];
    x0 = xtime(a0);
    x1 = xtime(a1);
    x2 = xtime(a2);
    x3 = xtime(a3);
    if (en) begin
      col_out = {x0 ^ a0 ^ a1 ^ a2 ^ x3,
                 a0 ^ a1 ^ x2 ^ x3 ^ a3,
                 a0 ^ x1 ^ x2 ^ a2 ^ a3,
                 x0 ^ x1 ^ a1 ^ a2 ^ a3};
    end else begin
      col_out = col_in;
    end
  end

endmodule

/* src/aes_round_transforms_unit.sv */
// ----------------------------------------------------------------------------
// AES round transforms unit
// SubBytes, ShiftRows and MixColumns on a 16-byte state, with two round modes.
//
// Channel  Signals                              Direction
// command  start, busy, action, in_col0..3      in
// result   done, out_col0..3                    out
//
// A state is taken in every cycle; its result appears with done in the next
// cycle. Four S-box lanes, a ShiftRows byte routing and four MixColumns lanes
// form one registered stage. busy is always low, as the receiver cannot stall.
// Reset clears done.
// ----------------------------------------------------------------------------
module aes_round_transforms_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      action,
  input  aesrt_pkg::col_t in_col0,
  input  aesrt_pkg::col_t in_col1,
  input  aesrt_pkg::col_t in_col2,
  input  aesrt_pkg::col_t in_col3,
  output logic            done,
  output aesrt_pkg::col_t out_col0,
  output aesrt_pkg::col_t out_col1,
  output aesrt_pkg::col_t out_col2,
  output aesrt_pkg::col_t out_col3
);
  import aesrt_pkg::*;

  ctl_t ctl;
  col_t in_c [NumCols];
  col_t sub_c [NumCols];
  col_t shf_c [NumCols];
  col_t mix_c [NumCols];

  always_comb begin
    ctl = '0;
    case (action)
      ACT_SUB:   ctl.do_sub = 1'b1;
      ACT_SHIFT: ctl.do_shift = 1'b1;
      ACT_MIX:   ctl.do_mix = 1'b1;
      ACT_ROUND: ctl = '{do_sub: 1'b1, do_shift: 1'b1, do_mix: 1'b1};
      ACT_FINAL: ctl = '{do_sub: 1'b1, do_shift: 1'b1, do_mix: 1'b0};
      default:   ctl = '0;
    endcase
  end

  assign in_c[0] = in_col0;
  assign in_c[1] = in_col1;
  assign in_c[2] = in_col2;
  assign in_c[3] = in_col3;

  for (genvar k = 0; k < NumCols; k++) begin : g_lane
    aesrt_sub_lane u_sub (.col_in(in_c[k]), .en(ctl.do_sub), .col_out(sub_c[k]));
    for (genvar r = 0; r < 4; r++) begin : g_row
      assign shf_c[k][8*r +: 8] = ctl.do_shift ? sub_c[(k + r) % NumCols][8*r +: 8]
                                               : sub_c[k][8*r +: 8];
    end
    aesrt_mix_lane u_mix (.col_in(shf_c[k]), .en(ctl.do_mix), .col_out(mix_c[k]));
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      out_col0 <= mix_c[0];
      out_col1 <= mix_c[1];
      out_col2 <= mix_c[2];
      out_col3 <= mix_c[3];
    end
  end

`ifndef NO_ASSERTIONS
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start |=> done) else $error("transfer not reported");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start |=> !done) else $error("result without transfer");
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (start && action > ACT_FINAL) |=> (out_col0 == $past(in_col0)))
    else $error("unused action altered state");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// AES round transforms unit testbench
// Drives random and directed states with every action code through the
// command port and checks each result against an independent S-box,
// ShiftRows and MixColumns prediction, in order of transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import aesrt_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam logic [2:0] ACT_NONE5 = 3'd5;
  localparam logic [2:0] ACT_NONE7 = 3'd7;

  typedef struct {
    logic [2:0] act;
    col_t       col [4];
    bit         drain;
  } cmd_t;

  typedef struct {
    col_t col [4];
  } state_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] action;
  col_t in_col0, in_col1, in_col2, in_col3;
  logic done;
  col_t out_col0, out_col1, out_col2, out_col3;

  cmd_t   pending_cmds [$];
  state_t expected_states [$];
  int     send_idle_pct;
  int     errors;
  int     quiet_cycles;
  bit     stimulus_done;
  bit     draining;

  logic [7:0] sub_table [256];

  aes_round_transforms_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .in_col0(in_col0), .in_col1(in_col1), .in_col2(in_col2), .in_col3(in_col3),
    .done(done), .out_col0(out_col0), .out_col1(out_col1), .out_col2(out_col2),
    .out_col3(out_col3)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [7:0] gf_double(logic [7:0] b);
    logic [8:0] v;
    v = {b, 1'b0};
    if (b[7]) begin
      v = v ^ 9'h11b;
    end
    return v[7:0];
  endfunction

  function automatic state_t transform_state(logic [2:0] act, col_t cols [4]);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    state_t res;
    bit sub_en, shift_en, mix_en;
    for (int i = 0; i < 16; i++) begin
      s[i] = cols[i / 4][8 * (i % 4) +: 8];
    end
    sub_en   = (act == ACT_SUB) || (act == ACT_ROUND) || (act == ACT_FINAL);
    shift_en = (act == ACT_SHIFT) || (act == ACT_ROUND) || (act == ACT_FINAL);
    mix_en   = (act == ACT_MIX) || (act == ACT_ROUND);
    if (sub_en) begin
      for (int i = 0; i < 16; i++) s[i] = sub_table[s[i]];
    end
    if (shift_en) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[c * 4 + r] = s[((c + r) % 4) * 4 + r];
      s = t;
    end
    if (mix_en) begin
      for (int c = 0; c < 4; c++) begin
        a0 = s[c * 4]; a1 = s[c * 4 + 1]; a2 = s[c * 4 + 2]; a3 = s[c * 4 + 3];
        s[c * 4]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
        s[c * 4 + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
        s[c * 4 + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
        s[c * 4 + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
      end
    end
    for (int i = 0; i < 16; i++) res.col[i / 4][8 * (i % 4) +: 8] = s[i];
    return res;
  endfunction

  // S-box built from the multiplicative inverse and the affine map.
  task automatic build_sub_table();
    logic [7:0] inv, p, x, y;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++) begin
        p = 8'h00; x = a[7:0]; y = b[7:0];
        for (int k = 0; k < 8; k++) begin
          if (y[0]) p = p ^ x;
          x = gf_double(x);
          y = y >> 1;
        end
        if (p == 8'h01) inv = b[7:0];
      end
      for (int k = 0; k < 8; k++) begin
        y[k] = inv[k] ^ inv[(k + 4) % 8] ^ inv[(k + 5) % 8] ^ inv[(k + 6) % 8]
             ^ inv[(k + 7) % 8];
      end
      sub_table[a] = y ^ 8'h63;
    end
  endtask

  task automatic queue_cmd(logic [2:0] act, col_t c0, col_t c1, col_t c2, col_t c3);
    cmd_t cmd;
    cmd.act = act;
    cmd.col[0] = c0; cmd.col[1] = c1; cmd.col[2] = c2; cmd.col[3] = c3;
    cmd.drain = 1'b0;
    pending_cmds.push_back(cmd);
  endtask

  task automatic queue_random(int count);
    logic [2:0] act;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      queue_cmd(act, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic wait_until_queued_sent();
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  // Driver: a new command is presented at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        void'(pending_cmds.pop_front());
      end
      if (pending_cmds.size() != 0 && pending_cmds[0].drain) begin
        start <= 1'b0;
        if (expected_states.size() == 0) void'(pending_cmds.pop_front());
      end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
      begin
        start   <= 1'b1;
        action  <= pending_cmds[0].act;
        in_col0 <= pending_cmds[0].col[0];
        in_col1 <= pending_cmds[0].col[1];
        in_col2 <= pending_cmds[0].col[2];
        in_col3 <= pending_cmds[0].col[3];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: records each accepted command and checks each result.
  always @(posedge clk) begin
    state_t exp_state;
    if (!rst) begin
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (done) begin
        if (expected_states.size() == 0) begin
          $display("%0t: result with none expected: %h %h %h %h", $time,
                   out_col0, out_col1, out_col2, out_col3);
          errors++;
        end else begin
          exp_state = expected_states.pop_front();
          if (exp_state.col[0] !== out_col0 || exp_state.col[1] !== out_col1 ||
              exp_state.col[2] !== out_col2 || exp_state.col[3] !== out_col3) begin
            $display("%0t: mismatch expected %h %h %h %h actual %h %h %h %h", $time,
                     exp_state.col[0], exp_state.col[1], exp_state.col[2],
                     exp_state.col[3], out_col0, out_col1, out_col2, out_col3);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        expected_states.push_back(transform_state(action,
                                  '{in_col0, in_col1, in_col2, in_col3}));
      end
    end
  end

  initial begin
    cmd_t hold;
    rst = 1'b1; start = 1'b0; action = ACT_SUB;
    in_col0 = '0; in_col1 = '0; in_col2 = '0; in_col3 = '0;
    errors = 0; quiet_cycles = 0; send_idle_pct = 18;
    build_sub_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int a = ACT_SUB; a <= ACT_NONE7; a++) begin
      queue_cmd(3'(a), 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
      queue_cmd(3'(a), 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    end
    queue_cmd(ACT_SHIFT, 32'h03020100, 32'h07060504, 32'h0b0a0908, 32'h0f0e0d0c);
    queue_cmd(ACT_MIX, 32'h455313db, 32'h5c220af2, 32'h01010101, 32'hd5d4d4c6);
    queue_cmd(ACT_ROUND, 32'h30e0bf19, 32'h9ae0b4a0, 32'hf18d2bf4, 32'h2811e3c4);
    queue_cmd(ACT_FINAL, 32'h80808080, 32'h01010101, 32'h7f7f7f7f, 32'hfefefefe);
    queue_cmd(ACT_NONE5, 32'h12345678, 32'h9abcdef0, 32'h0f1e2d3c, 32'h4b5a6978);
    queue_random(330);
    hold.drain = 1'b1;
    pending_cmds.push_back(hold);
    wait_until_queued_sent();
    send_idle_pct = 71;
    queue_random(330);
    wait_until_queued_sent();
    send_idle_pct = 0;
    queue_random(330);
    wait_until_queued_sent();
    @(negedge clk);
    while (expected_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    stimulus_done = 1'b1;
  end

  initial begin
    stimulus_done = 1'b0;
    wait (stimulus_done || quiet_cycles >= WatchdogLimit);
    if (!stimulus_done) begin
      $display("[aes_round_transforms_unit] ERROR");
    end else if (errors == 0) begin
      $display("[aes_round_transforms_unit] OK");
    end else begin
      $display("[aes_round_transforms_unit] ERROR");
    end
    $finish;
  end
endmodule
